### rtl/tks_pkg.sv
// ----------------------------------------------------------------------------
// tks_pkg: shared types and constants of the top-k sample mean block
// Field widths of the sample and result transactions and the control
// group that steers each cell of the sorted chain.
// ----------------------------------------------------------------------------
package tks_pkg;

    // Width of one sample and of the mean
    localparam int SAMPLE_W = 32;
    // Width of the used-count field of a result
    localparam int USED_W = 4;

    // Control group broadcast to every cell of the chain
    typedef struct packed {
        logic insert;   // compare-and-shift a new sample into the chain
        logic drain;    // shift every entry one place towards the head
    } cell_ctrl_t;

endpackage

### rtl/tks_if.sv
// ----------------------------------------------------------------------------
// tks_if: valid/ready channels of the top-k sample mean block
// tks_in_if carries sample transactions, tks_out_if carries results.
// ----------------------------------------------------------------------------
interface tks_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [tks_pkg::SAMPLE_W-1:0] sample;
    logic                                present;
    logic                                is_last;

    modport source (output valid, output sample, output present, output is_last,
                    input ready);
    modport sink   (input valid, input sample, input present, input is_last,
                    output ready);
endinterface

interface tks_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [tks_pkg::SAMPLE_W-1:0] mean_value;
    logic        [tks_pkg::USED_W-1:0]   used_count;

    modport source (output valid, output mean_value, output used_count, input ready);
    modport sink   (input valid, input mean_value, input used_count, output ready);
endinterface

### rtl/tks_cell.sv
// ----------------------------------------------------------------------------
// tks_cell: one entry of the sorted chain
// Holds one kept sample. On insert it either keeps its value, takes the new
// sample or takes its upper neighbour's value; on drain it takes its lower
// neighbour's value so that the chain empties through the head.
// ----------------------------------------------------------------------------
module tks_cell (
    input  logic                                clk,
    input  tks_pkg::cell_ctrl_t                 ctrl,
    input  logic                                valid,
    input  logic signed [tks_pkg::SAMPLE_W-1:0] sample,
    input  logic signed [tks_pkg::SAMPLE_W-1:0] prev_value,
    input  logic                                prev_gt,
    input  logic signed [tks_pkg::SAMPLE_W-1:0] next_value,
    output logic signed [tks_pkg::SAMPLE_W-1:0] value,
    output logic                                gt
);
    import tks_pkg::*;

    logic signed [SAMPLE_W-1:0] value_reg;
    logic signed [SAMPLE_W-1:0] value_next;

    // New sample belongs at or above this place
    assign gt = !valid || (sample > value_reg);

    // Select the next entry value
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.drain)
        begin
            value_next = next_value;
        end
        else if (ctrl.insert && gt)
        begin
            value_next = prev_gt ? prev_value : sample;
        end
    end

    // Hold the entry
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

### rtl/tks_div.sv
// ----------------------------------------------------------------------------
// tks_div: radix-2 signed-by-unsigned divider
// Divides the magnitude of the sum one quotient bit per cycle and restores
// the sign at the end, so the quotient truncates towards zero.
// ----------------------------------------------------------------------------
module tks_div #(
    parameter int DIVIDEND_W = 36,
    parameter int DIVISOR_W  = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [DIVIDEND_W-1:0]        dividend,
    input  logic        [DIVISOR_W-1:0]         divisor,
    output logic                                done,
    output logic signed [tks_pkg::SAMPLE_W-1:0] quotient
);
    import tks_pkg::*;

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;
    logic [STEP_W-1:0]     step_reg;
    logic [STEP_W-1:0]     step_next;
    logic                  neg_reg;
    logic                  neg_next;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVIDEND_W-1:0] quo_next;
    logic [DIVISOR_W-1:0]  div_reg;
    logic [DIVISOR_W-1:0]  div_next;

    logic [DIVIDEND_W-1:0] magnitude;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;
    logic [DIVIDEND_W-1:0] signed_quo;

    assign magnitude = dividend[DIVIDEND_W-1] ? (~dividend + 1'b1) : dividend;
    assign trial     = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff      = trial - {1'b0, div_reg};
    assign fits      = trial >= {1'b0, div_reg};

    // Load operands or advance one quotient bit
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(DIVIDEND_W);
            neg_next  = dividend[DIVIDEND_W-1];
            rem_next  = '0;
            quo_next  = magnitude;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_next  = {quo_reg[DIVIDEND_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Hold operands and partial results
    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    // Restore the sign of the quotient
    assign signed_quo = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign quotient   = signed_quo[SAMPLE_W-1:0];
    assign done       = done_reg;

endmodule

### rtl/top_k_sample_mean_top.sv
// ----------------------------------------------------------------------------
// top_k_sample_mean_top: mean of the largest samples of one spectrum
// Keeps the TOP_COUNT largest samples in a sorted chain of cells and, on
// the item marked last, gives their mean and count.
// ----------------------------------------------------------------------------
// Usage
//   samples: one transaction per sample (present = 1) or a bare end marker
//   (present = 0). is_last = 1 closes the spectrum and produces one result.
//   level: one result transaction per closed spectrum, mean_value (signed,
//   truncated towards zero, 0 for an empty spectrum) and used_count.
// Throughput: while the block is idle, samples that do not close a spectrum
//   are taken one per cycle; insertion into the chain is a single
//   compare-and-shift in every cell. Closing: the chain drains its k kept
//   entries one per cycle into the accumulator, then the divider yields one
//   quotient bit per cycle (36 bits at the default size). samples.ready is
//   low from the closing transaction until the result enters the output register.
// Stall: a result waits in the output register; new samples are taken
//   meanwhile, and the next closing transaction waits only if the register
//   is still full when its mean is ready.
// Reset: rst_n clears the kept count, the control state and the output
//   valid; the chain entries need no clearing.
// ----------------------------------------------------------------------------
module top_k_sample_mean_top #(
    parameter int TOP_COUNT = 10
) (
    input  logic      clk,
    input  logic      rst_n,
    tks_in_if.sink    samples,
    tks_out_if.source level
);
    import tks_pkg::*;

    localparam int CNT_W = $clog2(TOP_COUNT + 1);
    localparam int SUM_W = SAMPLE_W + $clog2(TOP_COUNT);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SUM,
        S_DIV,
        S_PUT
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic [CNT_W-1:0]           kept_count_reg;
    logic [CNT_W-1:0]           kept_count_next;
    logic [CNT_W-1:0]           k_reg;
    logic [CNT_W-1:0]           k_next;
    logic [CNT_W-1:0]           drain_cnt_reg;
    logic [CNT_W-1:0]           drain_cnt_next;
    logic signed [SUM_W-1:0]    acc_reg;
    logic signed [SUM_W-1:0]    acc_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [SAMPLE_W-1:0] mean_reg;
    logic signed [SAMPLE_W-1:0] mean_next;
    logic [USED_W-1:0]          used_reg;
    logic [USED_W-1:0]          used_next;

    logic                       accept;
    logic                       insert_ok;
    logic [CNT_W-1:0]           kept_after;
    cell_ctrl_t                 ctrl;
    logic                       div_start;
    logic                       div_done;
    logic signed [SAMPLE_W-1:0] div_quotient;

    logic signed [SAMPLE_W-1:0] cell_value [TOP_COUNT];
    logic                       cell_gt    [TOP_COUNT];

    assign accept = samples.valid && samples.ready;

    // Chain control: insert on a present sample, drain while summing
    assign ctrl = '{insert: accept && samples.present,
                    drain:  (state_reg == S_SUM) && (drain_cnt_reg != '0)};

    // Sorted chain, largest at the head
    for (genvar i = 0; i < TOP_COUNT; i++)
    begin : g_cell
        logic                       prev_gt;
        logic signed [SAMPLE_W-1:0] prev_value;
        logic signed [SAMPLE_W-1:0] next_value;

        if (i == 0)
        begin : g_head
            assign prev_gt    = 1'b0;
            assign prev_value = samples.sample;
        end
        else
        begin : g_body
            assign prev_gt    = cell_gt[i-1];
            assign prev_value = cell_value[i-1];
        end

        if (i == TOP_COUNT - 1)
        begin : g_tail
            assign next_value = '0;
        end
        else
        begin : g_inner
            assign next_value = cell_value[i+1];
        end

        tks_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .valid      (CNT_W'(i) < kept_count_reg),
            .sample     (samples.sample),
            .prev_value (prev_value),
            .prev_gt    (prev_gt),
            .next_value (next_value),
            .value      (cell_value[i]),
            .gt         (cell_gt[i])
        );
    end

    // Sample enters the chain when the tail entry would move
    assign insert_ok  = cell_gt[TOP_COUNT-1];
    assign kept_after = (ctrl.insert && insert_ok && (kept_count_reg < CNT_W'(TOP_COUNT)))
                        ? kept_count_reg + 1'b1 : kept_count_reg;

    assign div_start = (state_reg == S_SUM) && (drain_cnt_reg == '0);

    tks_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (k_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Sequence insertion, drain, division and result hand-off
    always_comb
    begin
        state_next      = state_reg;
        kept_count_next = kept_count_reg;
        k_next          = k_reg;
        drain_cnt_next  = drain_cnt_reg;
        acc_next        = acc_reg;
        out_valid_next  = out_valid_reg;
        mean_next       = mean_reg;
        used_next       = used_reg;

        if (level.valid && level.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kept_count_next = kept_after;
                    if (samples.is_last)
                    begin
                        kept_count_next = '0;
                        k_next          = kept_after;
                        drain_cnt_next  = kept_after;
                        acc_next        = '0;
                        state_next      = S_SUM;
                    end
                end
            end
            S_SUM:
            begin
                if (drain_cnt_reg == '0)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    acc_next       = acc_reg + SUM_W'(cell_value[0]);
                    drain_cnt_next = drain_cnt_reg - 1'b1;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                if (!out_valid_reg || level.ready)
                begin
                    out_valid_next = 1'b1;
                    mean_next      = (k_reg == '0) ? '0 : div_quotient;
                    used_next      = USED_W'(k_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            kept_count_reg <= '0;
            k_reg          <= '0;
            drain_cnt_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            kept_count_reg <= kept_count_next;
            k_reg          <= k_next;
            drain_cnt_reg  <= drain_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Hold sum and result payload
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        mean_reg <= mean_next;
        used_reg <= used_next;
    end

    assign samples.ready    = (state_reg == S_IDLE);
    assign level.valid      = out_valid_reg;
    assign level.mean_value = mean_reg;
    assign level.used_count = used_reg;

    // Kept count never exceeds the chain length
    assert property (@(posedge clk) disable iff (!rst_n)
        kept_count_reg <= CNT_W'(TOP_COUNT))
        else $error("kept count beyond chain length");

    // A closing transaction empties the chain
    assert property (@(posedge clk) disable iff (!rst_n)
        samples.valid && samples.ready && samples.is_last |=> kept_count_reg == '0)
        else $error("chain not emptied after closing transaction");

    // Divider finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside division phase");

    // A new result appears only from the hand-off state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_PUT)
        else $error("result raised outside hand-off");

    // Chain drains exactly k entries before division starts
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> drain_cnt_reg == '0 && k_reg <= CNT_W'(TOP_COUNT))
        else $error("division started with a bad count");

endmodule

### bench/top_k_sample_mean_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// top_k_sample_mean_top_test: self-checking bench of the top-k sample mean
// Streams spectra of signed samples into the block and keeps a sorted chain
// of the largest samples of its own to predict each mean and used count.
// Results are checked in order as they leave the block. Both channels idle at
// random, and one long receiver hold-off forces the block to stall its input.
// ----------------------------------------------------------------------------
module top_k_sample_mean_top_test;

    localparam int TOP_COUNT    = 10;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 80;
    localparam int RANDOM_ITEMS = 900;
    localparam int HOLD_CYCLES  = 400;

    typedef logic signed [tks_pkg::SAMPLE_W-1:0] sample_t;
    typedef logic        [tks_pkg::USED_W-1:0]   used_t;

    typedef struct {
        sample_t mean_value;
        used_t   used_count;
    } level_t;

    // Predict the signal level of each spectrum and check the block against it
    class level_scoreboard;
        sample_t chain [TOP_COUNT];
        int      held;
        level_t  pending_levels [$];
        int      failures;

        function new();
            held     = 0;
            failures = 0;
        endfunction

        // Compare-and-shift a sample into the chain, largest first
        function void insert_sample(sample_t s);
            int pos;
            int last;
            pos = 0;
            while (pos < held && chain[pos] >= s)
                pos++;
            if (pos >= TOP_COUNT)
                return;
            last = (held < TOP_COUNT) ? held : TOP_COUNT - 1;
            for (int i = last; i > pos; i--)
                chain[i] = chain[i - 1];
            chain[pos] = s;
            if (held < TOP_COUNT)
                held++;
        endfunction

        // Note an accepted sample transaction; a closing one yields a level
        function void note_sample(sample_t s, logic present, logic is_last);
            logic signed [63:0] total;
            logic signed [63:0] quotient;
            level_t             lvl;
            if (present)
                insert_sample(s);
            if (!is_last)
                return;
            total = 0;
            for (int i = 0; i < held; i++)
                total += chain[i];
            quotient = (held != 0) ? total / held : 64'sd0;
            lvl.mean_value = quotient[tks_pkg::SAMPLE_W-1:0];
            lvl.used_count = held[tks_pkg::USED_W-1:0];
            pending_levels = {pending_levels, lvl};
            held = 0;
        endfunction

        // Check one accepted result transaction against the oldest level
        function void check_level(sample_t mean_value, used_t used_count);
            level_t lvl;
            if (pending_levels.size() == 0)
            begin
                $error("unexpected level: mean_value %0d, used_count %0d",
                       mean_value, used_count);
                failures++;
                return;
            end
            lvl = pending_levels.pop_front();
            if (mean_value !== lvl.mean_value)
            begin
                $error("mean_value: expected %0d, actual %0d", lvl.mean_value, mean_value);
                failures++;
            end
            if (used_count !== lvl.used_count)
            begin
                $error("used_count: expected %0d, actual %0d", lvl.used_count, used_count);
                failures++;
            end
        endfunction

        function int outstanding();
            return pending_levels.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    tks_in_if  samples_if ();
    tks_out_if level_if ();

    level_scoreboard sb = new();

    int cycle_count;
    int hold_request;
    int burst_left;
    bit bursty;
    int counted_items;

    top_k_sample_mean_top #(
        .TOP_COUNT (TOP_COUNT)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .level   (level_if)
    );

    // Clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Abort a run that hangs
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("top_k_sample_mean_top_test: FAIL");
            $finish;
        end
    end

    // Offer one sample transaction, in bursty mode sometimes idling first when a burst has run out
    task automatic offer_item(input sample_t s, input logic present, input logic is_last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (bursty && gap > 0)
            begin
                samples_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        samples_if.valid   <= 1'b1;
        samples_if.sample  <= s;
        samples_if.present <= present;
        samples_if.is_last <= is_last;
        do
            @(posedge clk);
        while (!samples_if.ready);
        sb.note_sample(s, present, is_last);
        counted_items++;
    endtask

    // Hold the sender until every expected level has come back
    task automatic wait_levels_drained();
        samples_if.valid <= 1'b0;
        burst_left = 0;
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    // Draw a sample: full range, extremes, a narrow band for ties, or near a rail
    function automatic sample_t pick_sample();
        case ($urandom_range(0, 4))
            0: return sample_t'($urandom);
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            2: return sample_t'($urandom_range(0, 16)) - 32'sd8;
            3: return 32'sh7FFF_FFFF - sample_t'($urandom_range(0, 1000));
            default: return 32'sh8000_0000 + sample_t'($urandom_range(0, 1000));
        endcase
    endfunction

    // Send one spectrum of the given length with the odd ignored item inside it
    task automatic offer_spectrum(input int length);
        for (int i = 0; i < length; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                offer_item(sample_t'($urandom), 1'b0, 1'b0);
            offer_item(pick_sample(), 1'b1, 1'b0);
        end
        offer_item(pick_sample(), 1'($urandom_range(0, 1)), 1'b1);
    endtask

    // Receiver: check results, then stall on a pattern of changing modes
    initial
    begin : level_receiver
        int mode;
        int mode_left;
        int hold_left;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        level_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (level_if.valid === 1'b1 && level_if.ready === 1'b1)
                sb.check_level(level_if.mean_value, level_if.used_count);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                level_if.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0: level_if.ready <= 1'b1;
                    1: level_if.ready <= 1'($urandom_range(0, 1));
                    2: level_if.ready <= ($urandom_range(0, 4) == 0);
                    default: level_if.ready <= ($urandom_range(0, 15) == 0);
                endcase
            end
        end
    end

    // Stimulus
    initial
    begin : sample_sender
        rst_n              <= 1'b0;
        samples_if.valid   <= 1'b0;
        samples_if.sample  <= '0;
        samples_if.present <= 1'b0;
        samples_if.is_last <= 1'b0;
        hold_request  = 0;
        burst_left    = 0;
        bursty        = 1'b0;
        counted_items = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty spectrum, then a single sample at the top rail
        offer_item(32'sd0, 1'b0, 1'b1);
        offer_item(32'sh7FFF_FFFF, 1'b1, 1'b1);
        // Ignored item, negative mean truncated towards zero, bare end marker
        offer_item(32'sd12345, 1'b0, 1'b0);
        offer_item(-32'sd3, 1'b1, 1'b0);
        offer_item(-32'sd4, 1'b1, 1'b0);
        offer_item(32'sd99, 1'b0, 1'b1);
        // Full chain at the top rail, a tie with the smallest, a drop-out
        for (int i = 0; i < TOP_COUNT + 1; i++)
            offer_item(32'sh7FFF_FFFF, 1'b1, 1'b0);
        offer_item(32'sh8000_0000, 1'b1, 1'b1);
        // Bottom rail, closing item carries a sample
        for (int i = 0; i < 5; i++)
            offer_item(32'sh8000_0000, 1'b1, 1'b0);
        offer_item(32'sh8000_0000, 1'b1, 1'b1);

        // Hold off the receiver while short spectra keep coming
        wait_levels_drained();
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 8; i++)
            offer_spectrum(3);
        wait_levels_drained();

        // Random spectra, mostly short, a few past the chain length
        bursty = 1'b1;
        counted_items = 0;
        while (counted_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
                offer_spectrum($urandom_range(TOP_COUNT, 3 * TOP_COUNT));
            else
                offer_spectrum($urandom_range(0, 14));
            if ($urandom_range(0, 39) == 0)
                wait_levels_drained();
        end

        // Drain and report
        wait_levels_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.outstanding() == 0)
            $display("top_k_sample_mean_top_test: PASS");
        else
            $display("top_k_sample_mean_top_test: FAIL");
        $finish;
    end

endmodule
